>>> src/fpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsd_pkg
// Shared types and constants of the fall, posture and stillness detector.
// ----------------------------------------------------------------------------
package fpsd_pkg;

  // port widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_UPRIGHT_MIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HORIZONTAL_MAX   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_FALL_LEVEL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMPACT_LEVEL     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_FALL_MIN_MS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STILL_TOLERANCE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STILL_TIME_MS    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA     = 3'd7;

  // configuration reset values
  localparam logic [14:0] UPRIGHT_MIN_RST      = 15'd10650;
  localparam logic [15:0] HORIZONTAL_MAX_RST   = 16'd12288;
  localparam logic [15:0] FREE_FALL_LEVEL_RST  = 16'd6554;
  localparam logic [15:0] IMPACT_LEVEL_RST     = 16'd40960;
  localparam logic [15:0] FREE_FALL_MIN_MS_RST = 16'd100;
  localparam logic [15:0] STILL_TOLERANCE_RST  = 16'd1311;
  localparam logic [15:0] STILL_TIME_MS_RST    = 16'd3000;
  localparam logic [16:0] FILTER_ALPHA_RST     = 17'd3277;

  // filter weight of one in Q1.16
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // one g, the magnitude held before the first sample
  localparam logic [15:0] MAG_ONE_G = 16'd16384;

  // square root: two radicand bits and one result bit a step, top trial bit
  localparam int unsigned        ROOT_STEPS    = 16;
  localparam logic [31:0]        ROOT_BIT_INIT = 32'h4000_0000;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_SQ,    // square of the selected raw axis
    MUL_ALO,   // low part of filter difference times alpha
    MUL_AHI,   // high part of filter difference times alpha
    MUL_HX,    // horizontal x squared
    MUL_HZ,    // horizontal z squared
    MUL_HLIM   // horizontal limit squared
  } mul_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;       // capture a new word, clear the root unit
    logic [1:0] axis;       // axis for squares and the filter
    mul_src_t   mul_src;
    logic       mul_en;     // register a product
    logic       acc_add;    // accumulate a square
    logic       root_step;  // one square root iteration
    logic       diff_en;    // form the filter difference
    logic       prod_lo;    // load low partial product
    logic       prod_hi;    // add shifted high partial product
    logic       filt_upd;   // update the filter of the axis
    logic       hsum_ld;    // load horizontal sum
    logic       hsum_add;   // add to horizontal sum
    logic       commit;     // update detector state and the output word
  } cmd_t;

endpackage

>>> src/fall_posture_stillness_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fall_posture_stillness_detector
// Accelerometer magnitude, posture, two-phase fall and stillness detector.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one raw three-axis sample and its millisecond time
//   stamp; each accepted word yields exactly one output word with the
//   vector magnitude and the posture, fall and stillness flags.
//   The config channel writes the eight threshold registers (index 0..7);
//   cfg_ready is always high. Write only while no word is in flight.
//   One word is worked at a time, paced by the sequencer: four steps for
//   the three squares on the shared 25x25 multiplier, 16 square root
//   iterations (one result bit each), five steps per axis filter, three
//   steps for the horizontal magnitude test, one decision step and the
//   idle state, which takes the next word.
//   The output register decouples the sides: a new input word is taken
//   while the previous result waits; if the receiver still stalls when the
//   next result is ready, the sequencer holds in its decision step.
//   Reset (rst_n low, synchronous) restores the register defaults, clears
//   the filters and the fall and motion state, and sets the previous
//   magnitude to one g.
// ----------------------------------------------------------------------------
module fall_posture_stillness_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
  input  logic [fpsd_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // magnitude [15:0], upright [16], falling [17], fall_confirmed [18],
  // impact_rejected [19], still [20], zero [23:21]
  output logic [fpsd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fpsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fpsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  fpsd_pkg::cmd_t cmd;
  logic [15:0]    magnitude;
  logic           upright, falling, fall_confirmed, impact_rejected, still;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  fpsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fpsd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .accel_x         (in_tdata[15:0]),
    .accel_y         (in_tdata[31:16]),
    .accel_z         (in_tdata[47:32]),
    .now_ms          (in_tdata[79:48]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .magnitude       (magnitude),
    .upright         (upright),
    .falling         (falling),
    .fall_confirmed  (fall_confirmed),
    .impact_rejected (impact_rejected),
    .still           (still)
  );

  // pack the result word, lowest field first
  assign out_tdata = {3'b000, still, impact_rejected, fall_confirmed, falling,
                      upright, magnitude};

`ifndef SYNTHESIS
  // one word at a time: the sequencer leaves idle right after taking a word
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in flight");

  // a new result appears only from the decision step, never from idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a word in work");
`endif

endmodule

>>> src/fpsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsd_ctrl
// Sequencer: steps the datapath through squares, root, filters and decision.
// ----------------------------------------------------------------------------
module fpsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output fpsd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_FILT,
    S_HOR,
    S_FIN
  } state_t;

  localparam logic [3:0] SQ_LAST   = 4'd3;
  localparam logic [3:0] ROOT_LAST = 4'(fpsd_pkg::ROOT_STEPS - 1);
  localparam logic [3:0] FILT_LAST = 4'd4;
  localparam logic [3:0] HOR_LAST  = 4'd2;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_go;

  assign fin_go     = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.mul_src   = fpsd_pkg::MUL_SQ;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // product of step k is accumulated at step k+1
        cmd.axis    = cnt_r[1:0];
        cmd.mul_src = fpsd_pkg::MUL_SQ;
        cmd.mul_en  = (cnt_r != SQ_LAST);
        cmd.acc_add = (cnt_r != 4'd0);
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          axis_nxt  = fpsd_pkg::AXIS_X;
          state_nxt = S_FILT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_FILT: begin
        cmd.axis = axis_r;
        case (cnt_r)
          4'd0: cmd.diff_en = 1'b1;
          4'd1: begin
            cmd.mul_src = fpsd_pkg::MUL_ALO;
            cmd.mul_en  = 1'b1;
          end
          4'd2: begin
            cmd.mul_src = fpsd_pkg::MUL_AHI;
            cmd.mul_en  = 1'b1;
            cmd.prod_lo = 1'b1;
          end
          4'd3: cmd.prod_hi = 1'b1;
          4'd4: cmd.filt_upd = 1'b1;
          default: ;
        endcase
        if (cnt_r == FILT_LAST) begin
          cnt_nxt = '0;
          if (axis_r == fpsd_pkg::AXIS_Z) begin
            state_nxt = S_HOR;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_HOR: begin
        cmd.mul_en = 1'b1;
        case (cnt_r)
          4'd0: cmd.mul_src = fpsd_pkg::MUL_HX;
          4'd1: begin
            cmd.mul_src = fpsd_pkg::MUL_HZ;
            cmd.hsum_ld = 1'b1;
          end
          4'd2: begin
            cmd.mul_src  = fpsd_pkg::MUL_HLIM;
            cmd.hsum_add = 1'b1;
          end
          default: cmd.mul_en = 1'b0;
        endcase
        if (cnt_r == HOR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (fin_go) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      axis_r      <= fpsd_pkg::AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/fpsd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsd_dp
// Datapath: shared multiplier, square root, axis filters, detector state.
// ----------------------------------------------------------------------------
module fpsd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpsd_pkg::cmd_t                      cmd,
  input  logic signed [15:0]                  accel_x,
  input  logic signed [15:0]                  accel_y,
  input  logic signed [15:0]                  accel_z,
  input  logic        [31:0]                  now_ms,
  input  logic                                cfg_we,
  input  logic [fpsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fpsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [15:0]                         magnitude,
  output logic                                upright,
  output logic                                falling,
  output logic                                fall_confirmed,
  output logic                                impact_rejected,
  output logic                                still
);

  function automatic logic [32:0] abs33(input logic [32:0] v);
    logic [32:0] r;
    r = v;
    if (v[32]) r = ~v + 33'd1;
    return r;
  endfunction

  // configuration
  logic [14:0] upright_min_r;
  logic [15:0] horizontal_max_r;
  logic [15:0] free_fall_level_r;
  logic [15:0] impact_level_r;
  logic [15:0] free_fall_min_ms_r;
  logic [15:0] still_tolerance_r;
  logic [15:0] still_time_ms_r;
  logic [16:0] filter_alpha_r;

  // captured word
  logic signed [15:0] ax_r, ay_r, az_r;
  logic        [31:0] now_r;

  // arithmetic
  logic signed [49:0] mul_r;
  logic        [31:0] acc_r;
  logic        [31:0] res_r;
  logic        [31:0] bit_r;
  logic signed [33:0] diff_r;
  logic signed [49:0] prod_r;
  logic        [47:0] hsum_r;

  // detector state
  logic signed [32:0] filt_x_r, filt_y_r, filt_z_r;
  logic               in_ff_r, in_ff_nxt;
  logic        [31:0] ff_start_r, ff_start_nxt;
  logic        [15:0] prev_mag_r;
  logic        [31:0] last_motion_r, last_motion_nxt;

  // output word
  logic [15:0] out_mag_r;
  logic        out_upright_r, out_falling_r, out_conf_r, out_rej_r, out_still_r;

  logic signed [15:0] sel_raw;
  logic signed [32:0] sel_filt;
  logic        [16:0] alpha_eff;
  logic signed [24:0] mul_a, mul_b;
  logic        [32:0] abs_x, abs_y, abs_z;
  logic        [23:0] hx, hz;
  logic        [31:0] trial;
  logic        [33:0] filt_new;
  logic        [15:0] mag, delta;
  logic               mag_lt, mag_gt, impact, long_fall, upright_c, still_c, conf_c, rej_c;
  logic        [31:0] dur;

  always_comb begin
    case (cmd.axis)
      fpsd_pkg::AXIS_X: begin
        sel_raw  = ax_r;
        sel_filt = filt_x_r;
      end
      fpsd_pkg::AXIS_Y: begin
        sel_raw  = ay_r;
        sel_filt = filt_y_r;
      end
      fpsd_pkg::AXIS_Z: begin
        sel_raw  = az_r;
        sel_filt = filt_z_r;
      end
      default: begin
        sel_raw  = '0;
        sel_filt = '0;
      end
    endcase
  end

  assign alpha_eff = (filter_alpha_r > fpsd_pkg::ALPHA_ONE) ? fpsd_pkg::ALPHA_ONE
                                                            : filter_alpha_r;
  assign abs_x = abs33(filt_x_r);
  assign abs_y = abs33(filt_y_r);
  assign abs_z = abs33(filt_z_r);
  assign hx    = abs_x[31:8];
  assign hz    = abs_z[31:8];

  always_comb begin
    case (cmd.mul_src)
      fpsd_pkg::MUL_SQ: begin
        mul_a = {{9{sel_raw[15]}}, sel_raw};
        mul_b = mul_a;
      end
      fpsd_pkg::MUL_ALO: begin
        mul_a = {8'd0, diff_r[16:0]};
        mul_b = {8'd0, alpha_eff};
      end
      fpsd_pkg::MUL_AHI: begin
        mul_a = {{8{diff_r[33]}}, diff_r[33:17]};
        mul_b = {8'd0, alpha_eff};
      end
      fpsd_pkg::MUL_HX: begin
        mul_a = {1'b0, hx};
        mul_b = mul_a;
      end
      fpsd_pkg::MUL_HZ: begin
        mul_a = {1'b0, hz};
        mul_b = mul_a;
      end
      fpsd_pkg::MUL_HLIM: begin
        mul_a = {9'd0, horizontal_max_r};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign trial    = res_r + bit_r;
  assign filt_new = {sel_filt[32], sel_filt} + prod_r[49:16];

  // decision on the finished word
  assign mag       = res_r[15:0];
  assign mag_lt    = mag < free_fall_level_r;
  assign mag_gt    = mag > free_fall_level_r;
  assign impact    = in_ff_r && !mag_lt && (mag > impact_level_r);
  assign dur       = now_r - ff_start_r;
  assign long_fall = dur >= {16'd0, free_fall_min_ms_r};
  assign conf_c    = impact && long_fall;
  assign rej_c     = impact && !long_fall;
  assign upright_c = (abs_y > {2'b00, upright_min_r, 16'd0}) &&
                     (hsum_r < {mul_r[31:0], 16'd0});

  always_comb begin
    in_ff_nxt    = in_ff_r;
    ff_start_nxt = ff_start_r;
    if (mag_lt) begin
      in_ff_nxt = 1'b1;
      if (!in_ff_r) ff_start_nxt = now_r;
    end else if (mag_gt) begin
      in_ff_nxt = 1'b0;
    end
  end

  assign delta           = (mag > prev_mag_r) ? (mag - prev_mag_r) : (prev_mag_r - mag);
  assign last_motion_nxt = (delta > still_tolerance_r) ? now_r : last_motion_r;
  assign still_c         = (now_r - last_motion_nxt) >= {16'd0, still_time_ms_r};

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upright_min_r      <= fpsd_pkg::UPRIGHT_MIN_RST;
      horizontal_max_r   <= fpsd_pkg::HORIZONTAL_MAX_RST;
      free_fall_level_r  <= fpsd_pkg::FREE_FALL_LEVEL_RST;
      impact_level_r     <= fpsd_pkg::IMPACT_LEVEL_RST;
      free_fall_min_ms_r <= fpsd_pkg::FREE_FALL_MIN_MS_RST;
      still_tolerance_r  <= fpsd_pkg::STILL_TOLERANCE_RST;
      still_time_ms_r    <= fpsd_pkg::STILL_TIME_MS_RST;
      filter_alpha_r     <= fpsd_pkg::FILTER_ALPHA_RST;
      filt_x_r           <= '0;
      filt_y_r           <= '0;
      filt_z_r           <= '0;
      in_ff_r            <= 1'b0;
      ff_start_r         <= '0;
      prev_mag_r         <= fpsd_pkg::MAG_ONE_G;
      last_motion_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fpsd_pkg::REG_UPRIGHT_MIN:      upright_min_r      <= cfg_data[14:0];
          fpsd_pkg::REG_HORIZONTAL_MAX:   horizontal_max_r   <= cfg_data[15:0];
          fpsd_pkg::REG_FREE_FALL_LEVEL:  free_fall_level_r  <= cfg_data[15:0];
          fpsd_pkg::REG_IMPACT_LEVEL:     impact_level_r     <= cfg_data[15:0];
          fpsd_pkg::REG_FREE_FALL_MIN_MS: free_fall_min_ms_r <= cfg_data[15:0];
          fpsd_pkg::REG_STILL_TOLERANCE:  still_tolerance_r  <= cfg_data[15:0];
          fpsd_pkg::REG_STILL_TIME_MS:    still_time_ms_r    <= cfg_data[15:0];
          fpsd_pkg::REG_FILTER_ALPHA:     filter_alpha_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.filt_upd) begin
        case (cmd.axis)
          fpsd_pkg::AXIS_X: filt_x_r <= filt_new[32:0];
          fpsd_pkg::AXIS_Y: filt_y_r <= filt_new[32:0];
          fpsd_pkg::AXIS_Z: filt_z_r <= filt_new[32:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        in_ff_r       <= in_ff_nxt;
        ff_start_r    <= ff_start_nxt;
        prev_mag_r    <= mag;
        last_motion_r <= last_motion_nxt;
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r  <= accel_x;
      ay_r  <= accel_y;
      az_r  <= accel_z;
      now_r <= now_ms;
      acc_r <= '0;
      res_r <= '0;
      bit_r <= fpsd_pkg::ROOT_BIT_INIT;
    end
    if (cmd.mul_en) mul_r <= mul_a * mul_b;
    if (cmd.acc_add) acc_r <= acc_r + mul_r[31:0];
    if (cmd.root_step) begin
      if (acc_r >= trial) begin
        acc_r <= acc_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.diff_en) diff_r <= {{2{sel_raw[15]}}, sel_raw, 16'd0} - {sel_filt[32], sel_filt};
    if (cmd.prod_lo) prod_r <= mul_r;
    if (cmd.prod_hi) prod_r <= prod_r + (mul_r <<< 17);
    if (cmd.hsum_ld) hsum_r <= mul_r[47:0];
    if (cmd.hsum_add) hsum_r <= hsum_r + mul_r[47:0];
    if (cmd.commit) begin
      out_mag_r     <= mag;
      out_upright_r <= upright_c;
      out_falling_r <= in_ff_nxt;
      out_conf_r    <= conf_c;
      out_rej_r     <= rej_c;
      out_still_r   <= still_c;
    end
  end

  assign magnitude       = out_mag_r;
  assign upright         = out_upright_r;
  assign falling         = out_falling_r;
  assign fall_confirmed  = out_conf_r;
  assign impact_rejected = out_rej_r;
  assign still           = out_still_r;

endmodule
